>>> rtl/assert_macros.svh
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// clocked property, ignored while reset is asserted
`define MRPP_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// clocked property, checked during reset as well
`define MRPP_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`else

`define MRPP_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define MRPP_ASSERT_ALWAYS(lbl, clk_s, prop, msg)

`endif

`endif

>>> rtl/mrpp_pkg.sv
// shared constants and types for the max rescale pixel pair unit
package mrpp_pkg;

  localparam int unsigned FRAC_BITS = 8;
  // quotient width: pixel <= max keeps the quotient below 2^(8+FRAC_BITS)
  localparam int unsigned QUOT_W = 8 + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(QUOT_W);
  localparam logic [7:0] CUTOFF_RESET = 8'd20;
  localparam logic [31:0] FULL_SCALE = 32'(255) << FRAC_BITS;
  localparam logic [31:0] OUT_LIMIT = 32'h0000_FFFF;
  localparam logic [15:0] OUT_MAX =
    (FULL_SCALE > OUT_LIMIT) ? 16'hFFFF : FULL_SCALE[15:0];

  localparam logic KIND_MEASURE = 1'b0;
  localparam logic KIND_CONVERT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  typedef struct packed {
    logic measure;  // fold pair into maxima
    logic load;     // start a conversion
    logic step;     // one divider iteration
    logic publish;  // move quotients into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic last_step;
  } dp_status_t;

endpackage

>>> rtl/max_rescale_pixel_pair_unit.sv
// top level of the max rescale pixel pair unit
// Rescales paired 8-bit target and subject pixels so that each image's
// maximum maps to full scale, 8.8 fixed point (FRAC_BITS fraction bits).
// Feed each image pair twice: measure transactions (kind 0) fold both pixels
// into running maxima, with first set on the opening pair to clear them; then
// convert transactions (kind 1) return pixel*255*2^FRAC_BITS/max, truncated,
// one result per convert. A zero maximum gives zero, a pixel above its
// maximum saturates at full scale, and subject pixels at or below the
// cutoff register give zero. A measure transaction never stalls the
// input and the next can follow at once; a convert runs through the
// restoring divider, which retires one quotient bit per cycle for both
// pixels side by side. in_stall is high while a convert is in the divider
// and while its result waits for the output register; a finished result
// held in the output register does not block the next transaction. The
// cutoff is written through the cfg port, which is always ready; write it
// only while the unit is idle.
module max_rescale_pixel_pair_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic        in_first,
  input  logic [7:0]  in_target_pixel,
  input  logic [7:0]  in_subject_pixel,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_target_scaled,
  output logic [15:0] out_subject_scaled,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_subject_cutoff
);

`include "assert_macros.svh"

  mrpp_pkg::dp_cmd_t    cmd;
  mrpp_pkg::dp_status_t status;

  // the cutoff register takes a write on any cycle
  assign cfg_ready = 1'b1;

  // sequencing: accept, iterate the divider, hand over the result
  mrpp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // maxima, cutoff, divider lanes and output register
  mrpp_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_first           (in_first),
    .in_target_pixel    (in_target_pixel),
    .in_subject_pixel   (in_subject_pixel),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_subject_cutoff (cfg_subject_cutoff),
    .out_target_scaled  (out_target_scaled),
    .out_subject_scaled (out_subject_scaled)
  );

  // a convert transaction occupies the divider on the next cycle
  `MRPP_ASSERT(a_convert_busy, clk, rst_n,
    (in_valid && !in_stall && (in_kind == mrpp_pkg::KIND_CONVERT)) |=> in_stall,
    "convert accepted but unit not busy")

  // a measure transaction never makes a result appear
  `MRPP_ASSERT(a_measure_silent, clk, rst_n,
    (in_valid && !in_stall && (in_kind == mrpp_pkg::KIND_MEASURE) && !out_valid)
      |=> !out_valid,
    "result after measure transaction")

  // scaled values never pass full scale
  `MRPP_ASSERT(a_full_scale, clk, rst_n,
    out_valid |-> ((out_target_scaled <= mrpp_pkg::OUT_MAX) &&
                   (out_subject_scaled <= mrpp_pkg::OUT_MAX)),
    "scaled value above full scale")

  // the unit comes out of reset able to take a transaction
  `MRPP_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> (!in_stall && !out_valid),
    "unit not idle after reset")

endmodule

>>> rtl/mrpp_ctrl.sv
// controller state machine for the rescale unit
module mrpp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_kind,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  mrpp_pkg::dp_status_t status,
  output mrpp_pkg::dp_cmd_t    cmd
);

  mrpp_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic in_take;
  logic out_free;

  assign in_stall = (state_r != mrpp_pkg::ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    cmd.measure = 1'b0;
    cmd.load    = 1'b0;
    cmd.step    = 1'b0;
    cmd.publish = 1'b0;
    case (state_r)
      mrpp_pkg::ST_IDLE: begin
        if (in_take) begin
          if (in_kind == mrpp_pkg::KIND_CONVERT) begin
            cmd.load  = 1'b1;
            state_nxt = mrpp_pkg::ST_DIV;
          end else begin
            cmd.measure = 1'b1;
          end
        end
      end
      mrpp_pkg::ST_DIV: begin
        cmd.step = 1'b1;
        if (status.last_step) begin
          state_nxt = mrpp_pkg::ST_FIN;
        end
      end
      mrpp_pkg::ST_FIN: begin
        if (out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = mrpp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mrpp_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mrpp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/mrpp_dp.sv
// datapath: maxima, cutoff register, two-lane restoring divider, output register
module mrpp_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mrpp_pkg::dp_cmd_t    cmd,
  output mrpp_pkg::dp_status_t status,
  input  logic                 in_first,
  input  logic [7:0]           in_target_pixel,
  input  logic [7:0]           in_subject_pixel,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [7:0]           cfg_subject_cutoff,
  output logic [15:0]          out_target_scaled,
  output logic [15:0]          out_subject_scaled
);

  localparam int unsigned QW = mrpp_pkg::QUOT_W;
  localparam int unsigned CW = mrpp_pkg::CNT_W;

  logic [7:0]    cutoff_r;
  logic [7:0]    tmax_r, smax_r;
  logic [7:0]    tmax_nxt, smax_nxt;
  logic [CW-1:0] cnt_r;
  logic [7:0]    trem_r, srem_r;
  logic [QW-1:0] tlo_r, slo_r;
  logic          tzero_r, szero_r, tsat_r, ssat_r;
  logic [15:0]   tout_r, sout_r;

  logic [15:0]   tprod, sprod;
  logic [8:0]    ttrial, strial;
  logic          tge, sge;
  logic [31:0]   tval, sval;

  // pixel*255 as a shift and subtract
  assign tprod = {in_target_pixel, 8'h00} - 16'(in_target_pixel);
  assign sprod = {in_subject_pixel, 8'h00} - 16'(in_subject_pixel);

  assign ttrial = {trem_r, tlo_r[QW-1]};
  assign strial = {srem_r, slo_r[QW-1]};
  assign tge    = ttrial >= {1'b0, tmax_r};
  assign sge    = strial >= {1'b0, smax_r};

  assign status.last_step = (cnt_r == CW'(QW - 1));

  // first clears, then the pair is folded
  always_comb begin
    tmax_nxt = tmax_r;
    smax_nxt = smax_r;
    if (cmd.measure) begin
      if (in_first || (in_target_pixel > tmax_r)) begin
        tmax_nxt = in_target_pixel;
      end
      if (in_first || (in_subject_pixel > smax_r)) begin
        smax_nxt = in_subject_pixel;
      end
    end
  end

  always_comb begin
    if (tzero_r) begin
      tval = 32'd0;
    end else if (tsat_r) begin
      tval = mrpp_pkg::FULL_SCALE;
    end else begin
      tval = 32'(tlo_r);
    end
    if (szero_r) begin
      sval = 32'd0;
    end else if (ssat_r) begin
      sval = mrpp_pkg::FULL_SCALE;
    end else begin
      sval = 32'(slo_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= mrpp_pkg::CUTOFF_RESET;
      tmax_r   <= 8'd0;
      smax_r   <= 8'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cutoff_r <= cfg_subject_cutoff;
      end
      tmax_r <= tmax_nxt;
      smax_r <= smax_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load) begin
      cnt_r <= '0;
    end else if (cmd.step) begin
      cnt_r <= cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      trem_r  <= tprod[15:8];
      srem_r  <= sprod[15:8];
      tlo_r   <= QW'(tprod[7:0]) << mrpp_pkg::FRAC_BITS;
      slo_r   <= QW'(sprod[7:0]) << mrpp_pkg::FRAC_BITS;
      tzero_r <= (tmax_r == 8'd0);
      szero_r <= (smax_r == 8'd0) || (in_subject_pixel <= cutoff_r);
      tsat_r  <= (in_target_pixel > tmax_r);
      ssat_r  <= (in_subject_pixel > smax_r);
    end else if (cmd.step) begin
      trem_r <= tge ? 8'(ttrial - {1'b0, tmax_r}) : ttrial[7:0];
      srem_r <= sge ? 8'(strial - {1'b0, smax_r}) : strial[7:0];
      tlo_r  <= {tlo_r[QW-2:0], tge};
      slo_r  <= {slo_r[QW-2:0], sge};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      tout_r <= (tval > mrpp_pkg::OUT_LIMIT) ? 16'hFFFF : tval[15:0];
      sout_r <= (sval > mrpp_pkg::OUT_LIMIT) ? 16'hFFFF : sval[15:0];
    end
  end

  assign out_target_scaled  = tout_r;
  assign out_subject_scaled = sout_r;

endmodule

>>> sim/tb.sv
// testbench for the max rescale pixel pair unit: directed and random traffic checked against a predictor
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // idle time allowed after the results drain, before config writes
  localparam int unsigned CONVERT_CYCLES = 8 + mrpp_pkg::FRAC_BITS + 2;
  localparam int unsigned SETTLE_CYCLES = 2 * CONVERT_CYCLES + 4;

  // one expected result transaction
  typedef struct {
    logic [15:0] target_scaled;
    logic [15:0] subject_scaled;
  } scaled_pair_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_kind = mrpp_pkg::KIND_MEASURE;
  logic        in_first = 1'b0;
  logic [7:0]  in_target_pixel = 8'd0;
  logic [7:0]  in_subject_pixel = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_target_scaled;
  logic [15:0] out_subject_scaled;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_subject_cutoff = 8'd0;

  // predictor state: running maxima and the cutoff register as the block should hold them
  logic [7:0] peak_target = 8'd0;
  logic [7:0] peak_subject = 8'd0;
  logic [7:0] cutoff_level = mrpp_pkg::CUTOFF_RESET;

  // scaled pixel pairs still owed by the block, oldest first
  scaled_pair_t pending_scaled[$];

  int mismatches = 0;
  int send_idle_pct = 0;     // chance per cycle that the sender holds off
  int recv_stall_pct = 0;    // chance per cycle that the receiver stalls
  int long_hold_cycles = 0;  // when nonzero the receiver stalls solidly for this many cycles

  max_rescale_pixel_pair_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_first           (in_first),
    .in_target_pixel    (in_target_pixel),
    .in_subject_pixel   (in_subject_pixel),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_target_scaled  (out_target_scaled),
    .out_subject_scaled (out_subject_scaled),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_subject_cutoff (cfg_subject_cutoff)
  );

  always #4 clk = ~clk;

  // pixel*255 in fixed point over the peak, truncated; zero peak gives zero,
  // pixels above the peak clamp at full scale, and full scale clamps at 16 bits
  function automatic logic [15:0] rescale(input logic [7:0] pix, input logic [7:0] peak);
    logic [63:0] quot;
    logic [63:0] full_scale;
    if (peak == 8'd0) begin
      return 16'd0;
    end
    full_scale = 64'd255 << mrpp_pkg::FRAC_BITS;
    quot = ((64'(pix) * 64'd255) << mrpp_pkg::FRAC_BITS) / 64'(peak);
    if (quot > full_scale) begin
      quot = full_scale;
    end
    if (quot > 64'hFFFF) begin
      quot = 64'hFFFF;
    end
    return quot[15:0];
  endfunction

  // fold an accepted transaction into the predictor, queue its result if it converts
  task automatic predict_pair(input logic kind, input logic first,
                              input logic [7:0] tpix, input logic [7:0] spix);
    scaled_pair_t want;
    if (kind == mrpp_pkg::KIND_MEASURE) begin
      // first clears both maxima before this pair is folded in
      if (first) begin
        peak_target = 8'd0;
        peak_subject = 8'd0;
      end
      if (tpix > peak_target) peak_target = tpix;
      if (spix > peak_subject) peak_subject = spix;
    end else begin
      // first is ignored on converts; cutoff wins even over a zero peak
      want.target_scaled = rescale(tpix, peak_target);
      want.subject_scaled = (spix <= cutoff_level) ? 16'd0 : rescale(spix, peak_subject);
      pending_scaled.push_back(want);
    end
  endtask

  // offer one pixel pair and hold it until the block takes it; valid stays high on
  // return so a following call can go back to back without a low cycle
  task automatic send_pair(input logic kind, input logic first,
                           input logic [7:0] tpix, input logic [7:0] spix);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_first <= first;
    in_target_pixel <= tpix;
    in_subject_pixel <= spix;
    do @(posedge clk); while (in_stall);
    predict_pair(kind, first, tpix, spix);
  endtask

  // drop valid, let every owed result come back, then give the divider time to go quiet
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_scaled.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // cutoff register write, only ever issued with the block idle
  task automatic write_cutoff(input logic [7:0] level);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_subject_cutoff <= level;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cutoff_level = level;
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    send_idle_pct = sender_pct;
    recv_stall_pct = receiver_pct;
  endtask

  // random pixel: mostly within a bound, now and then a hard extreme
  function automatic logic [7:0] pick_pixel(input logic [7:0] bound);
    case ($urandom_range(9))
      0: return 8'd0;
      1: return bound;
      2: return 8'($urandom_range(255));
      default: return 8'($urandom_range(bound));
    endcase
  endfunction

  // receiver side: random stalls, or a solid hold-off when a test asks for one
  always @(posedge clk) begin
    if (long_hold_cycles > 0) begin
      out_stall <= 1'b1;
      long_hold_cycles = long_hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // every result transaction is compared with the oldest pending expectation
  always @(posedge clk) begin : check_results
    scaled_pair_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_scaled.size() == 0) begin
        $error("unexpected result: target_scaled %0d subject_scaled %0d",
               out_target_scaled, out_subject_scaled);
        mismatches++;
      end else begin
        want = pending_scaled.pop_front();
        if (out_target_scaled !== want.target_scaled) begin
          $error("target_scaled: expected %0d, actual %0d",
                 want.target_scaled, out_target_scaled);
          mismatches++;
        end
        if (out_subject_scaled !== want.subject_scaled) begin
          $error("subject_scaled: expected %0d, actual %0d",
                 want.subject_scaled, out_subject_scaled);
          mismatches++;
        end
      end
    end
  end

  // maxima straight out of reset are zero, so converts give zero on both sides
  task automatic test_reset_state();
    send_pair(mrpp_pkg::KIND_CONVERT, 1'b0, 8'd255, 8'd255);
    send_pair(mrpp_pkg::KIND_CONVERT, 1'b1, 8'd7, 8'd20);
    send_pair(mrpp_pkg::KIND_CONVERT, 1'b0, 8'd0, 8'd21);
    wait_drained();
  endtask

  // full scale, zero pixels, saturation above the peak, maxima carried without first
  task automatic test_directed_cases();
    send_pair(mrpp_pkg::KIND_MEASURE, 1'b1, 8'd255, 8'd255);
    send_pair(mrpp_pkg::KIND_CONVERT, 1'b0, 8'd255, 8'd255);
    send_pair(mrpp_pkg::KIND_CONVERT, 1'b0, 8'd0, 8'd0);
    send_pair(mrpp_pkg::KIND_CONVERT, 1'b1, 8'd1, 8'd21);
    send_pair(mrpp_pkg::KIND_MEASURE, 1'b1, 8'd100, 8'd50);
    send_pair(mrpp_pkg::KIND_CONVERT, 1'b0, 8'd200, 8'd255);  // both pixels above their peak
    send_pair(mrpp_pkg::KIND_CONVERT, 1'b0, 8'd100, 8'd50);
    send_pair(mrpp_pkg::KIND_MEASURE, 1'b0, 8'd50, 8'd60);     // raises the subject peak only
    send_pair(mrpp_pkg::KIND_CONVERT, 1'b0, 8'd99, 8'd59);
    send_pair(mrpp_pkg::KIND_MEASURE, 1'b1, 8'd0, 8'd0);       // zero peaks: no division
    send_pair(mrpp_pkg::KIND_CONVERT, 1'b0, 8'd5, 8'd30);
    send_pair(mrpp_pkg::KIND_MEASURE, 1'b1, 8'd1, 8'd128);
    send_pair(mrpp_pkg::KIND_CONVERT, 1'b0, 8'd1, 8'd20);      // subject exactly at cutoff
    wait_drained();
  endtask

  // cutoff register at both ends of its range, then back to its reset value
  task automatic test_cutoff_extremes();
    write_cutoff(8'd0);
    send_pair(mrpp_pkg::KIND_MEASURE, 1'b1, 8'd200, 8'd200);
    send_pair(mrpp_pkg::KIND_CONVERT, 1'b0, 8'd0, 8'd0);
    send_pair(mrpp_pkg::KIND_CONVERT, 1'b0, 8'd0, 8'd1);
    send_pair(mrpp_pkg::KIND_CONVERT, 1'b0, 8'd255, 8'd199);
    write_cutoff(8'd255);
    send_pair(mrpp_pkg::KIND_CONVERT, 1'b0, 8'd10, 8'd255);
    send_pair(mrpp_pkg::KIND_CONVERT, 1'b0, 8'd10, 8'd254);
    write_cutoff(mrpp_pkg::CUTOFF_RESET);
  endtask

  // one image: a measure pass then a convert pass over the same pixels, with the
  // occasional missing first flag, stray first mid pass or unrelated convert pixels
  task automatic send_image(output int sent);
    logic [7:0] tpix[64];
    logic [7:0] spix[64];
    logic [7:0] tbound;
    logic [7:0] sbound;
    logic       fresh_convert;
    int         npix;
    npix = ($urandom_range(9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 10);
    tbound = 8'($urandom_range(255));
    sbound = 8'($urandom_range(255));
    fresh_convert = ($urandom_range(9) == 0);
    for (int i = 0; i < npix; i++) begin
      tpix[i] = pick_pixel(tbound);
      spix[i] = pick_pixel(sbound);
      send_pair(mrpp_pkg::KIND_MEASURE,
                (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0),
                tpix[i], spix[i]);
    end
    for (int i = 0; i < npix; i++) begin
      if (fresh_convert) begin
        tpix[i] = 8'($urandom_range(255));
        spix[i] = 8'($urandom_range(255));
      end
      send_pair(mrpp_pkg::KIND_CONVERT, 1'($urandom_range(1)), tpix[i], spix[i]);
    end
    sent = 2 * npix;
  endtask

  // mostly well-formed images, with loose random transactions mixed in
  task automatic run_traffic(input int item_goal);
    int sent;
    int chunk;
    sent = 0;
    while (sent < item_goal) begin
      if ($urandom_range(99) < 15) begin
        send_pair(1'($urandom_range(1)), 1'($urandom_range(1)),
                  8'($urandom_range(255)), 8'($urandom_range(255)));
        sent++;
      end else begin
        send_image(chunk);
        sent += chunk;
      end
    end
    wait_drained();
  endtask

  // random traffic under each idling pattern, cutoff moved between phases
  task automatic test_random_traffic();
    set_idling(0, 0);
    run_traffic(320);
    write_cutoff(8'($urandom_range(255)));
    set_idling(48, 0);
    run_traffic(310);
    write_cutoff(8'($urandom_range(60)));
    set_idling(0, 48);
    run_traffic(310);
    write_cutoff(8'd255);
    set_idling(7, 7);
    run_traffic(150);
    write_cutoff(8'($urandom_range(255)));
    run_traffic(160);
  endtask

  // receiver holds off for a long stretch while converts keep coming, so the
  // output register fills and the block has to stall its input
  task automatic test_backpressure();
    write_cutoff(mrpp_pkg::CUTOFF_RESET);
    set_idling(0, 0);
    send_pair(mrpp_pkg::KIND_MEASURE, 1'b1,
              8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
    long_hold_cycles = 400;
    for (int i = 0; i < 40; i++) begin
      send_pair(mrpp_pkg::KIND_CONVERT, 1'($urandom_range(1)),
                8'($urandom_range(255)), 8'($urandom_range(255)));
    end
    wait_drained();
    set_idling(7, 7);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_directed_cases();
    test_cutoff_extremes();
    test_random_traffic();
    test_backpressure();
    if (mismatches == 0 && pending_scaled.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
